>>> rtl/tlvdf_pkg.sv
// Shared types and constants for the TLV frame deframer.
package tlvdf_pkg;

	// Result kind codes carried on the master tuser low bits
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// Header phase, one-hot
	typedef enum logic [3:0] {
		PH_TYPE    = 4'b0001,
		PH_LEN_HI  = 4'b0010,
		PH_LEN_LO  = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	// One result transaction
	typedef struct packed {
		logic        last;
		logic        first;
		logic [15:0] msg_length;
		logic [7:0]  payload_byte;
		logic [7:0]  msg_type;
		logic [1:0]  kind;
	} result_t;

endpackage

>>> rtl/tlv_frame_deframer_unit.sv
// TLV deframer top level: header parse, payload tagging and output skid buffer.
// Each result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one input byte per cycle while the skid entry is empty; header/count decision is combinational.
// Output register plus one skid entry keep s_axis_tready registered.
// Reset (arst_n low, asynchronous): phase to awaiting type byte, type, length and
// count to zero, output and skid empty.
module tlv_frame_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] end_of_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [7:0] msg_type, [15:8] payload_byte, [31:16] msg_length
	output logic [2:0]  m_axis_tuser,  // [1:0] kind, [2] first
	output logic        m_axis_tlast   // last
);

	tlvdf_pkg::phase_t  phase_q, phase_d;
	logic [7:0]         frame_type_q, frame_type_d;
	logic [15:0]        frame_length_q, frame_length_d;
	logic [15:0]        payload_count_q, payload_count_d;

	tlvdf_pkg::result_t res_d, out_q, skid_q;
	logic               res_valid;
	logic               out_valid_q, skid_valid_q;
	logic               in_fire, out_fire;
	logic [15:0]        len_new;
	logic [16:0]        count_next;
	logic               is_last;

	assign s_axis_tready = !skid_valid_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = out_valid_q && m_axis_tready;

	assign len_new    = {frame_length_q[15:8], s_axis_tdata};
	assign count_next = {1'b0, payload_count_q} + 17'd1;
	assign is_last    = count_next >= {1'b0, frame_length_q};

	// Header phase, field capture and result build
	always_comb begin
		phase_d         = phase_q;
		frame_type_d    = frame_type_q;
		frame_length_d  = frame_length_q;
		payload_count_d = payload_count_q;
		res_valid       = 1'b0;
		res_d           = '0;
		if (s_axis_tuser[0]) begin
			res_valid  = 1'b1;
			res_d.kind = tlvdf_pkg::KIND_END;
		end else begin
			unique case (phase_q)
				tlvdf_pkg::PH_TYPE: begin
					frame_type_d = s_axis_tdata;
					phase_d      = tlvdf_pkg::PH_LEN_HI;
				end
				tlvdf_pkg::PH_LEN_HI: begin
					frame_length_d = {s_axis_tdata, 8'd0};
					phase_d        = tlvdf_pkg::PH_LEN_LO;
				end
				tlvdf_pkg::PH_LEN_LO: begin
					frame_length_d  = len_new;
					payload_count_d = '0;
					if (len_new == 16'd0) begin
						phase_d        = tlvdf_pkg::PH_TYPE;
						res_valid      = 1'b1;
						res_d.kind     = tlvdf_pkg::KIND_EMPTY;
						res_d.msg_type = frame_type_q;
						res_d.first    = 1'b1;
						res_d.last     = 1'b1;
					end else begin
						phase_d = tlvdf_pkg::PH_PAYLOAD;
					end
				end
				tlvdf_pkg::PH_PAYLOAD: begin
					res_valid          = 1'b1;
					res_d.kind         = tlvdf_pkg::KIND_PAYLOAD;
					res_d.msg_type     = frame_type_q;
					res_d.payload_byte = s_axis_tdata;
					res_d.msg_length   = frame_length_q;
					res_d.first        = payload_count_q == 16'd0;
					res_d.last         = is_last;
					if (is_last) begin
						phase_d         = tlvdf_pkg::PH_TYPE;
						payload_count_d = '0;
					end else begin
						payload_count_d = count_next[15:0];
					end
				end
				default: begin
					phase_d = tlvdf_pkg::PH_TYPE;
				end
			endcase
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= tlvdf_pkg::PH_TYPE;
			frame_type_q    <= '0;
			frame_length_q  <= '0;
			payload_count_q <= '0;
		end else if (in_fire) begin
			phase_q         <= phase_d;
			frame_type_q    <= frame_type_d;
			frame_length_q  <= frame_length_d;
			payload_count_q <= payload_count_d;
		end
	end

	// Output register and skid entry control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire && res_valid) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire && res_valid) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.msg_length, out_q.payload_byte, out_q.msg_type};
	assign m_axis_tuser  = {out_q.first, out_q.kind};
	assign m_axis_tlast  = out_q.last;

`ifndef ASSERT_OFF
	// Skid entry only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// A frame in payload phase always has bytes left to receive
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == tlvdf_pkg::PH_PAYLOAD) |->
			(frame_length_q != 16'd0) && (payload_count_q < frame_length_q))
		else $error("payload phase with no bytes left");

	// Empty message is a complete message by itself
	a_empty_first_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == tlvdf_pkg::KIND_EMPTY) |-> (out_q.first && out_q.last))
		else $error("empty message without first and last");

	// A stalled output holds its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
		else $error("output changed while stalled");
`endif

endmodule
